// ===== design/amdfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared types and constants for the adjacency matrix depth-first search core.
// ----------------------------------------------------------------------------
package amdfs_pkg;

  localparam int VERTEX_W    = 4;
  localparam int VCOUNT_W    = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int MAX_RESULTS = 16;
  localparam int RCOUNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic latch_item;
    logic start_search;
    logic ins_read_a;
    logic ins_write_a;
    logic ins_write_b;
    logic pop;
    logic check;
    logic send;
    logic load;
    logic scan_step;
    logic finish_emit;
  } cmd_t;

  typedef struct packed {
    logic item_search;
    logic item_ok;
    logic stack_empty;
    logic popped_visited;
    logic out_free;
    logic at_limit;
    logic scan_done;
    logic pending_valid;
  } sts_t;

endpackage

// ===== design/amdfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdfs_ctrl
// Sequencer for edge inserts and the stack walk of a search.
// ----------------------------------------------------------------------------
module amdfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  amdfs_pkg::sts_t    sts,
  output amdfs_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_INS_RD = 10'b0000000010,
    ST_INS_WA = 10'b0000000100,
    ST_INS_WB = 10'b0000001000,
    ST_POP    = 10'b0000010000,
    ST_CHECK  = 10'b0000100000,
    ST_SEND   = 10'b0001000000,
    ST_LOAD   = 10'b0010000000,
    ST_SCAN   = 10'b0100000000,
    ST_FINISH = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          if (sts.item_ok) begin
            if (sts.item_search) begin
              cmd.start_search = 1'b1;
              state_next       = ST_POP;
            end else begin
              state_next = ST_INS_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        cmd.ins_read_a = 1'b1;
        state_next     = ST_INS_WA;
      end
      ST_INS_WA: begin
        cmd.ins_write_a = 1'b1;
        state_next      = ST_INS_WB;
      end
      ST_INS_WB: begin
        cmd.ins_write_b = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_POP: begin
        if (sts.stack_empty) begin
          state_next = ST_FINISH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.popped_visited) begin
          state_next = ST_POP;
        end else begin
          cmd.check  = 1'b1;
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!sts.pending_valid || sts.out_free) begin
          cmd.send   = 1'b1;
          state_next = sts.at_limit ? ST_FINISH : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_POP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!sts.pending_valid || sts.out_free) begin
          cmd.finish_emit = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/amdfs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdfs_dp
// Adjacency memory, search stack, visited marks, scan mask and result register.
// ----------------------------------------------------------------------------
module amdfs_dp #(
  parameter int MAX_VERTICES = 16,
  parameter int STACK_DEPTH  = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  amdfs_pkg::cmd_t                     cmd,
  output amdfs_pkg::sts_t                     sts,
  input  logic [amdfs_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_we,
  input  logic [amdfs_pkg::VCOUNT_W-1:0]      cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [amdfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  localparam int VI = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [amdfs_pkg::VERTEX_W-1:0] in_a;
  logic [amdfs_pkg::VERTEX_W-1:0] in_b;
  logic [amdfs_pkg::VERTEX_W-1:0] item_a;
  logic [amdfs_pkg::VERTEX_W-1:0] item_b;
  logic [amdfs_pkg::VCOUNT_W-1:0] vertex_count;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] adj_rd_raw;
  logic                    adj_rd_valid;
  logic [MAX_VERTICES-1:0] adj_rd_data;
  logic [VI-1:0]           adj_rd_addr;
  logic                    adj_we;
  logic [VI-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] one_bit;

  logic [VI-1:0] stack_mem [STACK_DEPTH];
  logic [CW-1:0] stack_count;
  logic [SW-1:0] st_rd_addr;
  logic [VI-1:0] st_rd_data;
  logic          st_we;
  logic [SW-1:0] st_waddr;
  logic [VI-1:0] st_wdata;
  logic          st_room;

  logic [MAX_VERTICES-1:0]        visited;
  logic [VI-1:0]                  cur;
  logic [VI-1:0]                  pending;
  logic                           pending_valid;
  logic [amdfs_pkg::RCOUNT_W-1:0] rcount;
  logic [MAX_VERTICES-1:0]        scan_mask;
  logic [MAX_VERTICES-1:0]        limit_mask;
  logic [VI-1:0]                  low_idx;

  logic                           out_valid;
  logic [VI-1:0]                  out_vertex;
  logic                           out_last;
  logic                           out_free;

  assign in_a = in_tdata[amdfs_pkg::VERTEX_W-1:0];
  assign in_b = in_tdata[2*amdfs_pkg::VERTEX_W-1:amdfs_pkg::VERTEX_W];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= amdfs_pkg::VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_a <= in_a;
      item_b <= in_b;
    end
  end

  // adjacency memory, read-modify-write per row
  always_comb begin
    if (cmd.ins_read_a) begin
      adj_rd_addr = VI'(item_a);
    end else if (cmd.ins_write_a) begin
      adj_rd_addr = VI'(item_b);
    end else begin
      adj_rd_addr = cur;
    end
  end

  assign adj_rd_data = adj_rd_valid ? adj_rd_raw : '0;
  assign one_bit     = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
  assign adj_we      = cmd.ins_write_a | cmd.ins_write_b;
  assign adj_waddr   = cmd.ins_write_a ? VI'(item_a) : VI'(item_b);
  assign adj_wdata   = adj_rd_data |
                       (cmd.ins_write_a ? (one_bit << VI'(item_b)) : (one_bit << VI'(item_a)));

  always_ff @(posedge clk) begin
    adj_rd_raw <= adj_mem[adj_rd_addr];
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid    <= '0;
      adj_rd_valid <= 1'b0;
    end else begin
      adj_rd_valid <= row_valid[adj_rd_addr];
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
    end
  end

  // neighbour scan
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      limit_mask[i] = (i < int'(vertex_count));
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (scan_mask[i]) begin
        low_idx = VI'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_mask <= adj_rd_data & limit_mask;
    end else if (cmd.scan_step) begin
      scan_mask <= scan_mask & (scan_mask - 1'b1);
    end
  end

  // search stack
  assign st_room    = (stack_count < CW'(STACK_DEPTH));
  assign st_rd_addr = SW'(stack_count - 1'b1);
  assign st_we      = cmd.start_search | (cmd.scan_step & st_room);
  assign st_waddr   = cmd.start_search ? '0 : SW'(stack_count);
  assign st_wdata   = cmd.start_search ? VI'(in_a) : low_idx;

  always_ff @(posedge clk) begin
    st_rd_data <= stack_mem[st_rd_addr];
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
  end

  // drop whatever a walk cut short at the result limit left behind
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
    end else if (cmd.start_search) begin
      stack_count <= CW'(1);
    end else if (cmd.pop) begin
      stack_count <= stack_count - 1'b1;
    end else if (cmd.scan_step && st_room) begin
      stack_count <= stack_count + 1'b1;
    end else if (cmd.finish_emit) begin
      stack_count <= '0;
    end
  end

  // visit bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      visited       <= '0;
      pending_valid <= 1'b0;
      rcount        <= '0;
    end else begin
      if (cmd.start_search) begin
        visited       <= '0;
        pending_valid <= 1'b0;
        rcount        <= '0;
      end
      if (cmd.check) begin
        visited[st_rd_data] <= 1'b1;
      end
      if (cmd.send) begin
        pending_valid <= 1'b1;
        rcount        <= rcount + 1'b1;
      end
      if (cmd.finish_emit) begin
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      cur <= st_rd_data;
    end
    if (cmd.send) begin
      pending <= cur;
    end
  end

  // result register
  assign out_free = !out_valid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_tready) begin
        out_valid <= 1'b0;
      end
      if ((cmd.send || cmd.finish_emit) && pending_valid) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.send || cmd.finish_emit) && pending_valid) begin
      out_vertex <= pending;
      out_last   <= cmd.finish_emit;
    end
  end

  assign out_tvalid = out_valid;
  assign out_tdata  = amdfs_pkg::OUT_TDATA_W'(amdfs_pkg::VERTEX_W'(out_vertex));
  assign out_tlast  = out_last;

  // status
  always_comb begin
    sts.item_search    = (in_tuser == amdfs_pkg::REQ_SEARCH);
    sts.item_ok        = (int'(in_a) < MAX_VERTICES) &&
                         (sts.item_search || (int'(in_b) < MAX_VERTICES));
    sts.stack_empty    = (stack_count == '0);
    sts.popped_visited = visited[st_rd_data];
    sts.out_free       = out_free;
    sts.at_limit       = (rcount == amdfs_pkg::RCOUNT_W'(amdfs_pkg::MAX_RESULTS - 1));
    sts.scan_done      = (scan_mask == '0);
    sts.pending_valid  = pending_valid;
  end

endmodule

// ===== design/adjacency_matrix_dfs_order_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_core
// Undirected adjacency matrix with an iterative depth-first search walk.
// ----------------------------------------------------------------------------
// One item at a time. An edge insert (tuser 0) steps through the accepting
// cycle, a read of the first row, a write of the first row overlapped with
// the read of the second, and a write of the second row. A search (tuser 1)
// seeds the stack as it is accepted, then pops and checks every stack entry;
// for every newly visited vertex it sends the vertex, loads its row and pushes
// its neighbours, and it closes once the stack is empty. The single write
// port of the stack memory sets the pace of the neighbour pushes. A search
// stops after 16 results, skipping the scan of the 16th vertex; the final
// result carries tlast. Every result and the close also wait for as long as
// the result register is held by the sink. The result register lets the next
// item be taken while the last result still waits. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_core #(
  parameter int MAX_VERTICES = 16,
  parameter int STACK_DEPTH  = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [amdfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // vertex_a[3:0], vertex_b[7:4]
  input  logic                                s_axis_tuser,  // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [amdfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // visited_vertex[3:0], zero[7:4]
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [amdfs_pkg::VCOUNT_W-1:0]      cfg_wdata      // vertex_count
);

  amdfs_pkg::cmd_t cmd;
  amdfs_pkg::sts_t sts;

  amdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  amdfs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tlast  (m_axis_tlast)
  );

  a_idle_stack_empty : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> sts.stack_empty)
    else $error("stack not empty while idle");

  a_idle_no_pending : assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !sts.pending_valid)
    else $error("held result left behind after a search");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("left idle without an accepted word");

endmodule

// ===== dv/adjacency_matrix_dfs_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_checker
// Watches both stream channels and the vertex-count port of the core. It keeps
// its own copy of the adjacency matrix and vertex count, works out the visit
// order of every accepted search word and compares each result word with the
// oldest predicted visit.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [amdfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [amdfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_we,
  input  logic [amdfs_pkg::VCOUNT_W-1:0]    cfg_wdata,
  output int                                fail_count,
  output int                                pending,
  output int                                visits_seen,
  output int                                searches_seen
);

  localparam int NUM_VERTICES = 16;
  localparam int WALK_DEPTH   = 512;

  typedef struct packed {
    logic [amdfs_pkg::VERTEX_W-1:0] vertex;
    logic                           last;
  } visit_t;

  logic [NUM_VERTICES-1:0]        adj_rows [NUM_VERTICES];
  logic [amdfs_pkg::VCOUNT_W-1:0] vcount;
  visit_t                         visit_order_q [$];
  visit_t                         want;
  logic [amdfs_pkg::VERTEX_W-1:0] end_a;
  logic [amdfs_pkg::VERTEX_W-1:0] end_b;
  int                             n_fail;
  int                             n_visits;
  int                             n_searches;

  task automatic predict_walk(input logic [amdfs_pkg::VERTEX_W-1:0] start);
    logic [amdfs_pkg::VERTEX_W-1:0] walk_stack [WALK_DEPTH];
    logic [NUM_VERTICES-1:0]        marked;
    logic [amdfs_pkg::VERTEX_W-1:0] v;
    visit_t                         item;
    int                             depth;
    int                             emitted;
    int                             scan_lim;
    scan_lim = (int'(vcount) > NUM_VERTICES) ? NUM_VERTICES : int'(vcount);
    marked = '0;
    emitted = 0;
    walk_stack[0] = start;
    depth = 1;
    while (depth > 0) begin
      depth--;
      v = walk_stack[depth];
      if (!marked[v]) begin
        marked[v] = 1'b1;
        if (emitted < amdfs_pkg::MAX_RESULTS) begin
          item.vertex = v;
          item.last   = 1'b0;
          visit_order_q.push_back(item);
          emitted++;
        end
        // push in ascending order so the highest neighbour comes off first
        for (int i = 0; i < scan_lim; i++) begin
          if (adj_rows[v][i] && depth < WALK_DEPTH) begin
            walk_stack[depth] = i[amdfs_pkg::VERTEX_W-1:0];
            depth++;
          end
        end
      end
    end
    if (emitted > 0) begin
      item = visit_order_q.pop_back();
      item.last = 1'b1;
      visit_order_q.push_back(item);
    end
  endtask

  function automatic void note_fail(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_VERTICES; r++) adj_rows[r] = '0;
      vcount = amdfs_pkg::VCOUNT_RESET;
      visit_order_q.delete();
      n_fail = 0;
      n_visits = 0;
      n_searches = 0;
    end else begin
      if (cfg_we) vcount = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        end_a = s_axis_tdata[3:0];
        end_b = s_axis_tdata[7:4];
        if (s_axis_tuser == amdfs_pkg::REQ_INSERT) begin
          adj_rows[end_a][end_b] = 1'b1;
          adj_rows[end_b][end_a] = 1'b1;
        end else begin
          predict_walk(end_a);
          n_searches++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_visits++;
        if (visit_order_q.size() == 0) begin
          note_fail($sformatf("unexpected result word: tdata %h last %0d",
                              m_axis_tdata, m_axis_tlast));
        end else begin
          want = visit_order_q.pop_front();
          if (m_axis_tdata !== {4'b0000, want.vertex} || m_axis_tlast !== want.last) begin
            note_fail($sformatf("mismatch: expected vertex %0d last %0d, got tdata %h last %0d",
                                want.vertex, want.last, m_axis_tdata, m_axis_tlast));
          end
        end
      end
    end
    fail_count    <= n_fail;
    pending       <= visit_order_q.size();
    visits_seen   <= n_visits;
    searches_seen <= n_searches;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the adjacency matrix depth-first search core. A
// directed part covers empty graphs, self loops, duplicate edges and the
// vertex-count corners; random phases then mix edge inserts and searches
// under random gaps on both channels. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;

  localparam int DRAIN_CYCLES = 1200;
  localparam int PHASES       = 5;
  localparam int PHASE_WORDS  = 18;

  logic                              clk;
  logic                              rst;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [amdfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [amdfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tlast;
  logic                              cfg_we;
  logic [amdfs_pkg::VCOUNT_W-1:0]    cfg_wdata;

  int   fail_count;
  int   pending;
  int   visits_seen;
  int   searches_seen;
  int   words_sent;
  int   cfg_writes;
  int   ready_hold;
  logic quiet;

  adjacency_matrix_dfs_order_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  adjacency_matrix_dfs_order_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .visits_seen   (visits_seen),
    .searches_seen (searches_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hold tready low for a random number of cycles after each result word
  always @(posedge clk) begin
    if (rst) begin
      ready_hold = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        ready_hold = quiet ? 0 : $urandom_range(0, 12);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
      m_axis_tready <= (ready_hold == 0);
    end
  end

  task automatic send_word(input logic req, input logic [3:0] va, input logic [3:0] vb);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vb, va};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // drop tvalid, wait for every predicted visit, then let the walk finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [amdfs_pkg::VCOUNT_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [amdfs_pkg::VCOUNT_W-1:0] phase_count;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = amdfs_pkg::REQ_INSERT;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    quiet         = 1'b0;
    words_sent    = 0;
    cfg_writes    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty graph, then a self loop, then a small tree with a duplicate edge
    send_word(amdfs_pkg::REQ_SEARCH, 4'd0, 4'd15);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd15, 4'd0);
    send_word(amdfs_pkg::REQ_INSERT, 4'd3, 4'd3);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd3, 4'd9);
    send_word(amdfs_pkg::REQ_INSERT, 4'd0, 4'd1);
    send_word(amdfs_pkg::REQ_INSERT, 4'd1, 4'd2);
    send_word(amdfs_pkg::REQ_INSERT, 4'd2, 4'd15);
    send_word(amdfs_pkg::REQ_INSERT, 4'd15, 4'd14);
    send_word(amdfs_pkg::REQ_INSERT, 4'd0, 4'd5);
    send_word(amdfs_pkg::REQ_INSERT, 4'd5, 4'd7);
    send_word(amdfs_pkg::REQ_INSERT, 4'd1, 4'd0);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd0, 4'd0);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd15, 4'd15);

    // vertex count of zero: start only
    write_vertex_count(5'd0);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd0, 4'd0);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd15, 4'd3);
    // saturating count
    write_vertex_count(5'd31);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd2, 4'd0);
    // start vertex not below the count
    write_vertex_count(5'd1);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd1, 4'd0);
    write_vertex_count(5'd3);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd15, 4'd0);
    send_word(amdfs_pkg::REQ_SEARCH, 4'd5, 4'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_count = 5'd16;
        1: phase_count = 5'($urandom_range(2, 15));
        2: phase_count = 5'($urandom_range(17, 31));
        3: phase_count = 5'd1;
        default: phase_count = 5'($urandom_range(0, 31));
      endcase
      write_vertex_count(phase_count);
      quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          send_word(amdfs_pkg::REQ_INSERT, 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)));
        end else begin
          send_word(amdfs_pkg::REQ_SEARCH, 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)));
        end
      end
    end
    quiet = 1'b0;
    wait_idle();

    $display("Covered %0d input words (%0d searches) and %0d result words",
             words_sent, searches_seen, visits_seen);
    $display("over %0d vertex-count settings, including zero, one and saturation",
             cfg_writes + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
